// ----- rtl/ras_rc_pkg.sv -----
// Package for the return address stack with repeat counters.
// Holds the request/response word types and the cell command codes.
// No dependencies.
`default_nettype none

package ras_rc_pkg;

    localparam int ADDR_W = 32;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] ret_addr;
    } ras_req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] target;
        logic              empty_res;
    } ras_resp_t;

    // Request codes
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // What a cell does at the next edge
    typedef enum logic [1:0] {
        CELL_HOLD,      // keep contents
        CELL_LOAD_PREV, // take the shallower neighbor's entry (push rotates down)
        CELL_LOAD_NEXT, // take the deeper neighbor's entry (pop rotates up)
        CELL_SET_CNT    // rewrite own counter
    } ras_cell_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/ras_rc_cell.sv -----
// One stack slot: a return address and its repeat counter.
// Depends on ras_rc_pkg for the cell command codes.
`default_nettype none

module ras_rc_cell
    import ras_rc_pkg::*;
#(
    parameter int COUNT_BITS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire ras_cell_cmd_t         cmd,
    input  wire logic [ADDR_W-1:0]     prev_addr,
    input  wire logic [COUNT_BITS-1:0] prev_cnt,
    input  wire logic [ADDR_W-1:0]     next_addr,
    input  wire logic [COUNT_BITS-1:0] next_cnt,
    input  wire logic [COUNT_BITS-1:0] set_cnt,
    output logic [ADDR_W-1:0]          addr,
    output logic [COUNT_BITS-1:0]      cnt
);

    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    always_comb begin
        addr_next = addr_reg;
        cnt_next  = cnt_reg;
        unique case (cmd)
            CELL_HOLD: begin
            end
            CELL_LOAD_PREV: begin
                addr_next = prev_addr;
                cnt_next  = prev_cnt;
            end
            CELL_LOAD_NEXT: begin
                addr_next = next_addr;
                cnt_next  = next_cnt;
            end
            CELL_SET_CNT: begin
                cnt_next = set_cnt;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            addr_reg <= addr_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign addr = addr_reg;
    assign cnt  = cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/return_address_stack_with_repeat_count_top.sv -----
// Top level of the return address stack with repeat counters.
// Depends on ras_rc_pkg and ras_rc_cell.
`default_nettype none

// Circular return address stack kept as a ring of STACK_DEPTH cells, with the
// top of stack always in cell 0. A push of a new address rotates the ring one
// place deeper and loads the address into cell 0 with count 1, dropping the
// oldest entry; a push equal to the top address only bumps cell 0's counter
// (saturating). A pop returns cell 0's address and decrements its counter;
// when the counter reaches zero the ring rotates back one place. A pop on a
// zero counter returns all ones with empty_res set. Every request, push or
// pop, yields one response word, valid in the cycle after the request is
// accepted. The whole ring updates at once, so with m_ready held high
// the block takes one request per clock. While a response word waits for
// m_ready the input stalls; the next request is taken in the same cycle that
// the waiting word leaves.
module return_address_stack_with_repeat_count_top
    import ras_rc_pkg::*;
#(
    parameter int STACK_DEPTH = 16,
    parameter int COUNT_BITS  = 8
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire ras_req_t  s_req,
    output logic           m_valid,
    input  wire logic      m_ready,
    output ras_resp_t      m_resp
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);

    logic [ADDR_W-1:0]     cell_addr [STACK_DEPTH];
    logic [COUNT_BITS-1:0] cell_cnt  [STACK_DEPTH];

    logic                  accept;
    logic                  is_pop;
    logic                  top_hit;
    logic                  top_empty;
    ras_cell_cmd_t         ring_cmd;
    logic [COUNT_BITS-1:0] top_set_cnt;
    ras_resp_t             resp_reg, resp_next;
    logic                  m_valid_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign is_pop    = (s_req.req_type == REQ_POP);
    assign top_hit   = (s_req.ret_addr == cell_addr[0]);
    assign top_empty = (cell_cnt[0] == '0);

    // Decide what the ring does for this request
    always_comb begin
        ring_cmd    = CELL_HOLD;
        top_set_cnt = cell_cnt[0];
        if (accept) begin
            if (!is_pop) begin
                if (top_hit) begin
                    ring_cmd    = CELL_SET_CNT;
                    top_set_cnt = (cell_cnt[0] == CNT_MAX) ? CNT_MAX : cell_cnt[0] + CNT_ONE;
                end else begin
                    ring_cmd = CELL_LOAD_PREV;
                end
            end else if (!top_empty) begin
                if (cell_cnt[0] == CNT_ONE) begin
                    ring_cmd = CELL_LOAD_NEXT;
                end else begin
                    ring_cmd    = CELL_SET_CNT;
                    top_set_cnt = cell_cnt[0] - CNT_ONE;
                end
            end
        end
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        ras_cell_cmd_t         cmd_i;
        logic [ADDR_W-1:0]     prev_addr_i, next_addr_i;
        logic [COUNT_BITS-1:0] prev_cnt_i, next_cnt_i;

        if (i == 0) begin : g_head
            assign cmd_i       = ring_cmd;
            assign prev_addr_i = s_req.ret_addr;
            assign prev_cnt_i  = CNT_ONE;
        end else begin : g_body
            // only the top cell rewrites its counter
            assign cmd_i       = (ring_cmd == CELL_SET_CNT) ? CELL_HOLD : ring_cmd;
            assign prev_addr_i = cell_addr[i-1];
            assign prev_cnt_i  = cell_cnt[i-1];
        end

        if (i == STACK_DEPTH - 1) begin : g_tail
            // the popped slot wraps to the far end with its counter cleared
            assign next_addr_i = cell_addr[0];
            assign next_cnt_i  = '0;
        end else begin : g_link
            assign next_addr_i = cell_addr[i+1];
            assign next_cnt_i  = cell_cnt[i+1];
        end

        ras_rc_cell #(
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd_i),
            .prev_addr (prev_addr_i),
            .prev_cnt  (prev_cnt_i),
            .next_addr (next_addr_i),
            .next_cnt  (next_cnt_i),
            .set_cnt   (top_set_cnt),
            .addr      (cell_addr[i]),
            .cnt       (cell_cnt[i])
        );
    end

    always_comb begin
        resp_next = '0;
        if (is_pop) begin
            if (top_empty) begin
                resp_next.target    = '1;
                resp_next.empty_res = 1'b1;
            end else begin
                resp_next.target = cell_addr[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            resp_reg <= resp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_resp  = resp_reg;

    a_resp_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted request produced no response word");

    a_empty_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_resp.empty_res |-> m_resp.target == '1)
        else $error("empty pop response without all-ones target");

    a_empty_pop_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_pop && top_empty |=> cell_cnt[0] == '0 && $stable(cell_addr[0]))
        else $error("pop on empty stack changed the top slot");

    a_new_push_top: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !is_pop && !top_hit |=>
            cell_cnt[0] == CNT_ONE && cell_addr[0] == $past(s_req.ret_addr))
        else $error("new push did not land in the top slot");

endmodule

`default_nettype wire
